// ===== src/rect_clip_with_texcoord_adjust_assert.svh =====
// ----------------------------------------------------------------------------
// rect clip assertion macros
// shorthand for the implication checks used by the port checker
// ----------------------------------------------------------------------------
`ifndef RECT_CLIP_WITH_TEXCOORD_ADJUST_ASSERT_SVH
`define RECT_CLIP_WITH_TEXCOORD_ADJUST_ASSERT_SVH

// same-cycle implication
`define RCTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rect clip check failed");

// next-cycle implication
`define RCTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rect clip check failed");

`endif

// ===== src/rcta_pkg.sv =====
// ----------------------------------------------------------------------------
// rcta_pkg
// shared types and constants of the quad clipper
// ----------------------------------------------------------------------------
`default_nettype none

package rcta_pkg;

	localparam int POS_W      = 20;
	localparam int TEX_W      = 16;
	localparam int DIV_STAGES = 17;
	localparam int NUM_W      = 38;
	localparam int DEN2_W     = 21;
	localparam int LANE_LAT   = DIV_STAGES + 2;
	localparam int NUM_LANES  = 4;

	localparam logic signed [POS_W-1:0] POS_MIN = -20'sd524288;
	localparam logic signed [POS_W-1:0] POS_MAX = 20'sd524287;
	localparam logic [TEX_W-1:0]        TEX_MAX = 16'hffff;

	localparam logic [1:0] MODE_RECT  = 2'd0;
	localparam logic [1:0] MODE_ICON  = 2'd1;
	localparam logic [1:0] MODE_GLYPH = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [2:0] REG_OFFSET_X   = 3'd0;
	localparam logic [2:0] REG_OFFSET_Y   = 3'd1;
	localparam logic [2:0] REG_AREA_MIN_X = 3'd2;
	localparam logic [2:0] REG_AREA_MIN_Y = 3'd3;
	localparam logic [2:0] REG_AREA_MAX_X = 3'd4;
	localparam logic [2:0] REG_AREA_MAX_Y = 3'd5;

	// lane order
	localparam int LANE_U_MIN = 0;
	localparam int LANE_V_MIN = 1;
	localparam int LANE_U_MAX = 2;
	localparam int LANE_V_MAX = 3;

	typedef struct packed {
		logic [1:0]              mode;
		logic signed [POS_W-1:0] x_min;
		logic signed [POS_W-1:0] y_min;
		logic signed [POS_W-1:0] x_max;
		logic signed [POS_W-1:0] y_max;
		logic [TEX_W-1:0]        u_min;
		logic [TEX_W-1:0]        v_min;
		logic [TEX_W-1:0]        u_max;
		logic [TEX_W-1:0]        v_max;
		logic [15:0]             glyph_scale;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
	} item_t;

	typedef struct packed {
		logic                    visible;
		logic [1:0]              kind;
		logic signed [POS_W-1:0] out_x_min;
		logic signed [POS_W-1:0] out_y_min;
		logic signed [POS_W-1:0] out_x_max;
		logic signed [POS_W-1:0] out_y_max;
		logic [TEX_W-1:0]        out_u_min;
		logic [TEX_W-1:0]        out_v_min;
		logic [TEX_W-1:0]        out_u_max;
		logic [TEX_W-1:0]        out_v_max;
	} result_t;

	typedef struct packed {
		logic signed [POS_W-1:0] offset_x;
		logic signed [POS_W-1:0] offset_y;
		logic signed [POS_W-1:0] area_min_x;
		logic signed [POS_W-1:0] area_min_y;
		logic signed [POS_W-1:0] area_max_x;
		logic signed [POS_W-1:0] area_max_y;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]        delta;
		logic signed [TEX_W:0]   span;
		logic [POS_W-1:0]        den;
	} lane_in_t;

	typedef struct packed {
		logic [DIV_STAGES-1:0]   quo;
		logic                    neg;
	} lane_out_t;

	typedef struct packed {
		logic                    visible;
		logic [1:0]              kind;
		logic signed [POS_W-1:0] cx0;
		logic signed [POS_W-1:0] cy0;
		logic signed [POS_W-1:0] cx1;
		logic signed [POS_W-1:0] cy1;
		logic [NUM_LANES-1:0]    need;
		logic [NUM_LANES-1:0][TEX_W-1:0] tex;
	} side_t;

endpackage

`default_nettype wire

// ===== src/rcta_front.sv =====
// ----------------------------------------------------------------------------
// rcta_front
// glyph scaling, offset, saturation and clipping against the draw area
// ----------------------------------------------------------------------------
`default_nettype none

module rcta_front import rcta_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire item_t                        item,
	input  wire cfg_t                         cfg,
	output logic                              out_valid,
	output side_t                             side,
	output lane_in_t [NUM_LANES-1:0]          lane
);

	function automatic logic signed [POS_W-1:0] corner_pos(
		input logic                    glyph,
		input logic signed [POS_W-1:0] ext,
		input logic signed [36:0]      prod,
		input logic signed [POS_W-1:0] pos,
		input logic signed [POS_W-1:0] off
	);
		logic signed [36:0] rnd;
		logic signed [30:0] sum;
		rnd = prod + 37'sd128;
		if (glyph) begin
			sum = 31'(rnd >>> 8) + 31'(pos) + 31'(off);
		end else begin
			sum = 31'(ext) + 31'(off);
		end
		if (sum < 31'(POS_MIN)) begin
			return POS_MIN;
		end else if (sum > 31'(POS_MAX)) begin
			return POS_MAX;
		end
		return POS_W'(sum);
	endfunction

	logic                     v_s1, v_s2, v_s3;
	item_t                    w_s1, w_s2;
	logic signed [36:0]       prod_s1 [4];
	logic signed [POS_W-1:0]  cr_s2 [4];
	side_t                    side_s3;
	lane_in_t [NUM_LANES-1:0] lane_s3;

	logic signed [POS_W-1:0]  ext [4];
	logic signed [POS_W-1:0]  crn [4];
	logic                     glyph;
	logic signed [POS_W-1:0]  a, b, c, d, cx0, cy0, cx1, cy1;
	logic                     vis;
	side_t                    side_n;
	lane_in_t [NUM_LANES-1:0] lane_n;

	assign ext[0] = item.x_min;
	assign ext[1] = item.y_min;
	assign ext[2] = item.x_max;
	assign ext[3] = item.y_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: glyph extent products
	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= item;
			for (int i = 0; i < 4; i++) begin
				prod_s1[i] <= 37'(ext[i]) * 37'($signed({1'b0, item.glyph_scale}));
			end
		end
	end

	// stage 2: round, add pen and offset, saturate
	assign glyph = (w_s1.mode == MODE_GLYPH);
	assign crn[0] = corner_pos(glyph, w_s1.x_min, prod_s1[0], w_s1.pos_x, cfg.offset_x);
	assign crn[1] = corner_pos(glyph, w_s1.y_min, prod_s1[1], w_s1.pos_y, cfg.offset_y);
	assign crn[2] = corner_pos(glyph, w_s1.x_max, prod_s1[2], w_s1.pos_x, cfg.offset_x);
	assign crn[3] = corner_pos(glyph, w_s1.y_max, prod_s1[3], w_s1.pos_y, cfg.offset_y);

	always_ff @(posedge clk) begin
		if (en) begin
			w_s2 <= w_s1;
			for (int i = 0; i < 4; i++) begin
				cr_s2[i] <= crn[i];
			end
		end
	end

	// stage 3: clip and set up the lanes
	assign a = cr_s2[0];
	assign b = cr_s2[1];
	assign c = cr_s2[2];
	assign d = cr_s2[3];
	assign cx0 = (a > cfg.area_min_x) ? a : cfg.area_min_x;
	assign cy0 = (b > cfg.area_min_y) ? b : cfg.area_min_y;
	assign cx1 = (c < cfg.area_max_x) ? c : cfg.area_max_x;
	assign cy1 = (d < cfg.area_max_y) ? d : cfg.area_max_y;

	always_comb begin
		vis = (w_s2.mode != MODE_NONE) && (cx1 > cx0) && (cy1 > cy0) &&
			((w_s2.mode == MODE_RECT) || ((c > a) && (d > b)));
		side_n.visible = vis;
		side_n.kind    = w_s2.mode;
		side_n.cx0     = cx0;
		side_n.cy0     = cy0;
		side_n.cx1     = cx1;
		side_n.cy1     = cy1;
		side_n.need[LANE_U_MIN] = (a < cfg.area_min_x);
		side_n.need[LANE_V_MIN] = (b < cfg.area_min_y);
		side_n.need[LANE_U_MAX] = (c > cfg.area_max_x);
		side_n.need[LANE_V_MAX] = (d > cfg.area_max_y);
		side_n.tex[LANE_U_MIN]  = w_s2.u_min;
		side_n.tex[LANE_V_MIN]  = w_s2.v_min;
		side_n.tex[LANE_U_MAX]  = w_s2.u_max;
		side_n.tex[LANE_V_MAX]  = w_s2.v_max;

		lane_n[LANE_U_MIN].delta = POS_W'(21'(cfg.area_min_x) - 21'(a));
		lane_n[LANE_V_MIN].delta = POS_W'(21'(cfg.area_min_y) - 21'(b));
		lane_n[LANE_U_MAX].delta = POS_W'(21'(c) - 21'(cfg.area_max_x));
		lane_n[LANE_V_MAX].delta = POS_W'(21'(d) - 21'(cfg.area_max_y));
		lane_n[LANE_U_MIN].span  = $signed({1'b0, w_s2.u_max}) - $signed({1'b0, w_s2.u_min});
		lane_n[LANE_U_MAX].span  = lane_n[LANE_U_MIN].span;
		lane_n[LANE_V_MIN].span  = $signed({1'b0, w_s2.v_max}) - $signed({1'b0, w_s2.v_min});
		lane_n[LANE_V_MAX].span  = lane_n[LANE_V_MIN].span;
		lane_n[LANE_U_MIN].den   = POS_W'(21'(c) - 21'(a));
		lane_n[LANE_U_MAX].den   = lane_n[LANE_U_MIN].den;
		lane_n[LANE_V_MIN].den   = POS_W'(21'(d) - 21'(b));
		lane_n[LANE_V_MAX].den   = lane_n[LANE_V_MIN].den;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_n;
			lane_s3 <= lane_n;
		end
	end

	assign out_valid = v_s3;
	assign side      = side_s3;
	assign lane      = lane_s3;

endmodule

`default_nettype wire

// ===== src/rcta_lane.sv =====
// ----------------------------------------------------------------------------
// rcta_lane
// one texcoord lane: delta times span, then a one-bit-per-stage rounding divide
// ----------------------------------------------------------------------------
`default_nettype none

module rcta_lane import rcta_pkg::*; (
	input  wire logic     clk,
	input  wire logic     en,
	input  wire lane_in_t li,
	output lane_out_t     lo
);

	logic [35:0]           mag_s1;
	logic                  neg_s1;
	logic [POS_W-1:0]      den_s1;
	logic [TEX_W-1:0]      span_abs;

	logic [NUM_W-1:0]      rem_s [DIV_STAGES+1];
	logic [DEN2_W-1:0]     d2_s  [DIV_STAGES+1];
	logic [DIV_STAGES-1:0] quo_s [DIV_STAGES+1];
	logic                  neg_s [DIV_STAGES+1];

	assign span_abs = li.span[TEX_W] ? TEX_W'(-li.span) : TEX_W'(li.span);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1   <= 36'(li.delta) * 36'(span_abs);
			neg_s1   <= li.span[TEX_W];
			den_s1   <= li.den;
			// numerator 2*mag + den, divisor 2*den
			rem_s[0] <= {1'b0, mag_s1, 1'b0} + NUM_W'(den_s1);
			d2_s[0]  <= {den_s1, 1'b0};
			quo_s[0] <= '0;
			neg_s[0] <= neg_s1;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
		logic [NUM_W-1:0] sub;
		logic [NUM_W:0]   diff;

		assign sub  = NUM_W'(d2_s[k]) << (DIV_STAGES - 1 - k);
		assign diff = {1'b0, rem_s[k]} - {1'b0, sub};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= diff[NUM_W] ? rem_s[k] : diff[NUM_W-1:0];
				quo_s[k+1] <= {quo_s[k][DIV_STAGES-2:0], ~diff[NUM_W]};
				d2_s[k+1]  <= d2_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign lo.quo = quo_s[DIV_STAGES];
	assign lo.neg = neg_s[DIV_STAGES];

endmodule

`default_nettype wire

// ===== src/rcta_merge.sv =====
// ----------------------------------------------------------------------------
// rcta_merge
// aligns the clip results with the lanes, applies the adjustments, output skid
// ----------------------------------------------------------------------------
`default_nettype none

module rcta_merge import rcta_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire side_t                      side,
	input  wire lane_out_t [NUM_LANES-1:0]  lane,
	input  wire logic                       result_ready,
	output logic                            en,
	output logic                            result_valid,
	output result_t                         result
);

	function automatic logic [TEX_W-1:0] sat_tex(input logic signed [18:0] v);
		if (v < 19'sd0) begin
			return '0;
		end else if (v > 19'sd65535) begin
			return TEX_MAX;
		end
		return TEX_W'(v);
	endfunction

	side_t   side_s [LANE_LAT];
	logic    v_s    [LANE_LAT];
	side_t   sd;
	result_t res_n;
	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic [NUM_LANES-1:0][TEX_W-1:0] tex_n;

	assign en = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 1; i < LANE_LAT; i++) begin
				v_s[i] <= v_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side;
			for (int i = 1; i < LANE_LAT; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign sd = side_s[LANE_LAT-1];

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			logic signed [18:0] adj;
			logic signed [18:0] sum;
			adj = lane[i].neg ? -19'($signed({1'b0, lane[i].quo})) :
				19'($signed({1'b0, lane[i].quo}));
			if (i == LANE_U_MIN || i == LANE_V_MIN) begin
				sum = $signed({3'b000, sd.tex[i]}) + adj;
			end else begin
				sum = $signed({3'b000, sd.tex[i]}) - adj;
			end
			tex_n[i] = sd.need[i] ? sat_tex(sum) : sd.tex[i];
		end

		res_n = '0;
		res_n.kind = sd.kind;
		if (sd.visible) begin
			res_n.visible   = 1'b1;
			res_n.out_x_min = sd.cx0;
			res_n.out_y_min = sd.cy0;
			res_n.out_x_max = sd.cx1;
			res_n.out_y_max = sd.cy1;
			if (sd.kind == MODE_RECT) begin
				res_n.out_u_min = '0;
				res_n.out_v_min = '0;
				res_n.out_u_max = TEX_MAX;
				res_n.out_v_max = TEX_MAX;
			end else begin
				res_n.out_u_min = tex_n[LANE_U_MIN];
				res_n.out_v_min = tex_n[LANE_V_MIN];
				res_n.out_u_max = tex_n[LANE_U_MAX];
				res_n.out_v_max = tex_n[LANE_V_MAX];
			end
		end
	end

	// output word plus skid word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !result_ready) begin
			if (en && v_s[LANE_LAT-1]) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= v_s[LANE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !result_ready) begin
			if (en && v_s[LANE_LAT-1]) begin
				skid_q <= res_n;
			end
		end else if (skid_valid_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= res_n;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// ===== src/rect_clip_with_texcoord_adjust.sv =====
// ----------------------------------------------------------------------------
// rect_clip_with_texcoord_adjust
// scissor clip of ui quads with texture coordinate correction
// ----------------------------------------------------------------------------
// Takes one quad word per clock unless the skid word is full, and returns one
// result word per quad, in order. Three front stages scale glyphs, add the
// offset and clip; four parallel lanes each run a multiply and a 17-stage
// one-bit-per-stage divider for the edge texcoord shifts; a merge stage
// applies them into an output register backed by a skid word, so input stays
// open while one finished word waits. The user writes registers through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
`default_nettype none

module rect_clip_with_texcoord_adjust import rcta_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire item_t            item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output result_t               result,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [POS_W-1:0] cfg_data
);

	cfg_t                      cfg_q;
	logic                      en;
	logic                      front_valid;
	side_t                     side;
	lane_in_t  [NUM_LANES-1:0] lane_in;
	lane_out_t [NUM_LANES-1:0] lane_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x   <= '0;
			cfg_q.offset_y   <= '0;
			cfg_q.area_min_x <= POS_MIN;
			cfg_q.area_min_y <= POS_MIN;
			cfg_q.area_max_x <= POS_MAX;
			cfg_q.area_max_y <= POS_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFFSET_X:   cfg_q.offset_x   <= cfg_data;
				REG_OFFSET_Y:   cfg_q.offset_y   <= cfg_data;
				REG_AREA_MIN_X: cfg_q.area_min_x <= cfg_data;
				REG_AREA_MIN_Y: cfg_q.area_min_y <= cfg_data;
				REG_AREA_MAX_X: cfg_q.area_max_x <= cfg_data;
				REG_AREA_MAX_Y: cfg_q.area_max_y <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item_ready = en;

	rcta_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (item_valid),
		.item      (item),
		.cfg       (cfg_q),
		.out_valid (front_valid),
		.side      (side),
		.lane      (lane_in)
	);

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		rcta_lane u_lane (
			.clk (clk),
			.en  (en),
			.li  (lane_in[i]),
			.lo  (lane_out[i])
		);
	end

	rcta_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (front_valid),
		.side         (side),
		.lane         (lane_out),
		.result_ready (result_ready),
		.en           (en),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== src/rcta_checker.sv =====
// ----------------------------------------------------------------------------
// rcta_checker
// port-level checks on the result word of the quad clipper
// ----------------------------------------------------------------------------
`default_nettype none

`include "rect_clip_with_texcoord_adjust_assert.svh"

module rcta_checker import rcta_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_ready,
	input wire item_t            item,
	input wire logic             result_valid,
	input wire logic             result_ready,
	input wire result_t          result,
	input wire logic             cfg_we,
	input wire logic [2:0]       cfg_index,
	input wire logic [POS_W-1:0] cfg_data
);

	`RCTA_ASSERT_IMP(a_hidden_zero, clk, arst_n, result_valid && !result.visible, result.out_x_min == 0 && result.out_y_min == 0 && result.out_x_max == 0 && result.out_y_max == 0 && result.out_u_min == 0 && result.out_v_min == 0 && result.out_u_max == 0 && result.out_v_max == 0)
	`RCTA_ASSERT_IMP(a_span_pos, clk, arst_n, result_valid && result.visible, result.out_x_max > result.out_x_min && result.out_y_max > result.out_y_min)
	`RCTA_ASSERT_IMP(a_rect_tex, clk, arst_n, result_valid && result.visible && result.kind == MODE_RECT, result.out_u_min == 0 && result.out_v_min == 0 && result.out_u_max == TEX_MAX && result.out_v_max == TEX_MAX)
	`RCTA_ASSERT_IMP(a_none_hidden, clk, arst_n, result_valid && result.kind == MODE_NONE, !result.visible)
	`RCTA_ASSERT_NXT(a_out_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))

endmodule

bind rect_clip_with_texcoord_adjust rcta_checker u_rcta_checker (.*);

`default_nettype wire

// ===== test/rect_clip_with_texcoord_adjust_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_clip_with_texcoord_adjust_check
// predicts each clipped quad and compares it with the block's result words
// ----------------------------------------------------------------------------
// Watches both handshakes and the register write port, keeps its own copy of
// the draw-area registers, computes the expected clip and texcoord shift for
// every accepted quad and matches result words in order.
`default_nettype none

module rect_clip_with_texcoord_adjust_check import rcta_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire logic             item_ready,
	input  wire item_t            item,
	input  wire logic             result_valid,
	input  wire logic             result_ready,
	input  wire result_t          result,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [POS_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);

	cfg_t    regs;
	result_t clip_q[$];

	function automatic longint sat_pos(longint v);
		if (v < -524288) return -524288;
		if (v > 524287) return 524287;
		return v;
	endfunction

	function automatic longint sat_tex(longint v);
		if (v < 0) return 0;
		if (v > 65535) return 65535;
		return v;
	endfunction

	function automatic longint scaled_extent(longint ext, longint sc);
		longint p;
		p = ext * sc + 128;
		if (p >= 0) return p >>> 8;
		return -((-p + 255) >>> 8);
	endfunction

	function automatic longint tex_shift(longint delta, longint span, longint den);
		longint num, mag, q;
		num = delta * span;
		mag = (num < 0) ? -num : num;
		q = (2 * mag + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	function automatic result_t clip_quad(item_t it, cfg_t c);
		result_t r;
		longint a, b, cc, d, cx0, cy0, cx1, cy1, u0, v0, u1, v1;
		longint amx, amy, axx, axy;
		r = '0;
		r.kind = it.mode;
		if (it.mode == MODE_NONE) return r;
		amx = c.area_min_x; amy = c.area_min_y;
		axx = c.area_max_x; axy = c.area_max_y;
		if (it.mode == MODE_GLYPH) begin
			a  = scaled_extent(it.x_min, it.glyph_scale) + it.pos_x + c.offset_x;
			b  = scaled_extent(it.y_min, it.glyph_scale) + it.pos_y + c.offset_y;
			cc = scaled_extent(it.x_max, it.glyph_scale) + it.pos_x + c.offset_x;
			d  = scaled_extent(it.y_max, it.glyph_scale) + it.pos_y + c.offset_y;
		end else begin
			a  = longint'(it.x_min) + c.offset_x;
			b  = longint'(it.y_min) + c.offset_y;
			cc = longint'(it.x_max) + c.offset_x;
			d  = longint'(it.y_max) + c.offset_y;
		end
		a = sat_pos(a); b = sat_pos(b); cc = sat_pos(cc); d = sat_pos(d);
		cx0 = (a > amx) ? a : amx;
		cy0 = (b > amy) ? b : amy;
		cx1 = (cc < axx) ? cc : axx;
		cy1 = (d < axy) ? d : axy;
		if (cx1 <= cx0 || cy1 <= cy0) return r;
		if (it.mode == MODE_RECT) begin
			u0 = 0; v0 = 0; u1 = TEX_MAX; v1 = TEX_MAX;
		end else begin
			if (cc <= a || d <= b) return r;
			u0 = it.u_min; v0 = it.v_min; u1 = it.u_max; v1 = it.v_max;
			if (a < amx) u0 = sat_tex(it.u_min + tex_shift(amx - a,
				longint'(it.u_max) - it.u_min, cc - a));
			if (b < amy) v0 = sat_tex(it.v_min + tex_shift(amy - b,
				longint'(it.v_max) - it.v_min, d - b));
			if (cc > axx) u1 = sat_tex(it.u_max - tex_shift(cc - axx,
				longint'(it.u_max) - it.u_min, cc - a));
			if (d > axy) v1 = sat_tex(it.v_max - tex_shift(d - axy,
				longint'(it.v_max) - it.v_min, d - b));
		end
		r.visible   = 1'b1;
		r.out_x_min = cx0[POS_W-1:0];
		r.out_y_min = cy0[POS_W-1:0];
		r.out_x_max = cx1[POS_W-1:0];
		r.out_y_max = cy1[POS_W-1:0];
		r.out_u_min = u0[TEX_W-1:0];
		r.out_v_min = v0[TEX_W-1:0];
		r.out_u_max = u1[TEX_W-1:0];
		r.out_v_max = v1[TEX_W-1:0];
		return r;
	endfunction

	always_comb pending = clip_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			regs.offset_x   <= '0;
			regs.offset_y   <= '0;
			regs.area_min_x <= POS_MIN;
			regs.area_min_y <= POS_MIN;
			regs.area_max_x <= POS_MAX;
			regs.area_max_y <= POS_MAX;
			errors = 0;
			clip_q.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (clip_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word %h", result);
				end else begin
					want = clip_q.pop_front();
					if (result !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch vis %b/%b kind %0d/%0d",
								want.visible, result.visible, want.kind, result.kind);
							$display("  x %0d %0d / %0d %0d  y %0d %0d / %0d %0d",
								want.out_x_min, want.out_x_max, result.out_x_min,
								result.out_x_max, want.out_y_min, want.out_y_max,
								result.out_y_min, result.out_y_max);
							$display("  uv %0d %0d %0d %0d / %0d %0d %0d %0d",
								want.out_u_min, want.out_v_min, want.out_u_max,
								want.out_v_max, result.out_u_min, result.out_v_min,
								result.out_u_max, result.out_v_max);
						end
					end
				end
			end
			if (item_valid && item_ready)
				clip_q.push_back(clip_quad(item, regs));
			if (cfg_we) begin
				case (cfg_index)
					REG_OFFSET_X:   regs.offset_x   <= cfg_data;
					REG_OFFSET_Y:   regs.offset_y   <= cfg_data;
					REG_AREA_MIN_X: regs.area_min_x <= cfg_data;
					REG_AREA_MIN_Y: regs.area_min_y <= cfg_data;
					REG_AREA_MAX_X: regs.area_max_x <= cfg_data;
					REG_AREA_MAX_Y: regs.area_max_y <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== test/rect_clip_with_texcoord_adjust_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_clip_with_texcoord_adjust_test
// stimulus and verdict for the quad clipper
// ----------------------------------------------------------------------------
// Drives directed edge quads and then random phases under several draw-area
// settings, with random gaps and stalls on both sides, a long output stall
// and a full drain; the checker module does all comparison.
`default_nettype none

module rect_clip_with_texcoord_adjust_test;
	import rcta_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	item_t            item;
	logic             result_valid;
	logic             result_ready;
	result_t          result;
	logic             cfg_we;
	logic [2:0]       cfg_index;
	logic [POS_W-1:0] cfg_data;
	int               errors;
	int               pending;
	int               cycles;
	bit               hold_off;

	rect_clip_with_texcoord_adjust u_top (.*);

	rect_clip_with_texcoord_adjust_check u_check (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// output side: random stalls, and a long hold-off on request
	initial begin
		int gap;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				result_ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	function automatic logic [POS_W-1:0] any_pos();
		case ($urandom_range(0, 5))
			0: return POS_MIN;
			1: return POS_MAX;
			2: return POS_W'($urandom());
			default: return POS_W'($signed($urandom_range(0, 8000)) - 4000);
		endcase
	endfunction

	function automatic item_t any_quad(bit tidy);
		item_t q;
		int w, h;
		q = '0;
		q.mode = tidy ? 2'($urandom_range(0, 2)) : 2'($urandom_range(0, 3));
		q.u_min = 16'($urandom()); q.v_min = 16'($urandom());
		q.u_max = 16'($urandom()); q.v_max = 16'($urandom());
		q.glyph_scale = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
			16'($urandom_range(0, 1024));
		q.pos_x = any_pos(); q.pos_y = any_pos();
		if (tidy) begin
			w = $urandom_range(1, 3000); h = $urandom_range(1, 3000);
			q.x_min = POS_W'($signed($urandom_range(0, 8000)) - 5000);
			q.y_min = POS_W'($signed($urandom_range(0, 8000)) - 5000);
			if (q.mode == MODE_GLYPH) begin
				q.x_min = POS_W'($signed($urandom_range(0, 400)) - 200);
				q.y_min = POS_W'($signed($urandom_range(0, 400)) - 200);
				w = w / 8 + 1; h = h / 8 + 1;
				q.pos_x = POS_W'($signed($urandom_range(0, 4000)) - 2000);
				q.pos_y = POS_W'($signed($urandom_range(0, 4000)) - 2000);
			end
			q.x_max = POS_W'(q.x_min + w); q.y_max = POS_W'(q.y_min + h);
		end else begin
			q.x_min = any_pos(); q.y_min = any_pos();
			q.x_max = any_pos(); q.y_max = any_pos();
		end
		return q;
	endfunction

	task automatic send_quad(item_t q);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= q;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [POS_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_area(logic [POS_W-1:0] ox, logic [POS_W-1:0] oy,
		logic [POS_W-1:0] x0, logic [POS_W-1:0] y0,
		logic [POS_W-1:0] x1, logic [POS_W-1:0] y1);
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_OFFSET_Y, oy);
		write_reg(REG_AREA_MIN_X, x0);
		write_reg(REG_AREA_MIN_Y, y0);
		write_reg(REG_AREA_MAX_X, x1);
		write_reg(REG_AREA_MAX_Y, y1);
		cfg_we <= 1'b0;
	endtask

	initial begin
		item_t q;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_off = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed quads at reset settings, then a tight area
		for (int k = 0; k < 2; k++) begin
			for (int m = 0; m < 4; m++) begin
				q = '0;
				q.mode = m[1:0];
				q.x_min = POS_MIN; q.y_min = POS_MIN;
				q.x_max = POS_MAX; q.y_max = POS_MAX;
				q.u_min = 16'h0000; q.u_max = TEX_MAX;
				q.v_min = TEX_MAX; q.v_max = 16'h0000;
				q.glyph_scale = 16'hffff;
				q.pos_x = POS_MAX; q.pos_y = POS_MIN;
				send_quad(q);
			end
			q = '0; q.mode = MODE_ICON; q.x_min = 20'sd100; q.x_max = 20'sd100;
			q.y_min = 20'sd0; q.y_max = 20'sd50;
			send_quad(q);
			q.x_max = 20'sd40;
			send_quad(q);
			q = '0; q.mode = MODE_GLYPH; q.x_min = -20'sd300; q.y_min = -20'sd300;
			q.x_max = 20'sd300; q.y_max = 20'sd300; q.glyph_scale = 16'h0180;
			q.u_max = TEX_MAX; q.v_max = TEX_MAX;
			send_quad(q);
			q.glyph_scale = 16'h0000;
			send_quad(q);
			q = '0; q.mode = MODE_ICON; q.x_min = -20'sd3; q.y_min = -20'sd3;
			q.x_max = 20'sd3; q.y_max = 20'sd3; q.u_max = 16'd3; q.v_max = 16'hfffd;
			send_quad(q);
			drain();
			if (k == 0)
				set_area(20'sd7, -20'sd5, -20'sd100, -20'sd1, 20'sd101, 20'sd2);
		end

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: set_area(POS_MIN, POS_MAX, POS_MIN, POS_MIN, POS_MAX, POS_MAX);
				1: set_area(20'sd0, 20'sd0, -20'sd1000, -20'sd1000, 20'sd1000, 20'sd1000);
				2: set_area(20'sd300, -20'sd200, 20'sd0, 20'sd0, 20'sd2000, 20'sd500);
				3: set_area(20'sd0, 20'sd0, 20'sd500, 20'sd500, -20'sd500, -20'sd500);
				4: set_area(POS_MAX, POS_MIN, -20'sd2000, -20'sd2000, 20'sd100, 20'sd100);
				default: set_area(POS_W'($urandom()), POS_W'($urandom()), -20'sd3000,
					-20'sd2500, 20'sd1500, 20'sd2000);
			endcase
			if (ph == 2) hold_off = 1;
			for (int n = 0; n < 165; n++) begin
				send_quad(any_quad($urandom_range(0, 9) < 8));
				if (n == 80) drain();
			end
		end
		drain();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
